>>> hdl/tlvp_pkg.sv
// Shared types and constants for the header/value message parser.
`timescale 1ns / 1ps

package tlvp_pkg;

    localparam int unsigned BYTE_W = 8;

    // Header id codes
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_REQUEST = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_CAPS    = 2'd3;

    localparam logic [BYTE_W-1:0] REQUEST_MAX    = 8'd2;
    localparam logic [BYTE_W-1:0] SIZE_REQUIRED  = 8'd1;
    localparam logic [BYTE_W-1:0] END_BYTE       = 8'd0;
    localparam logic [BYTE_W-1:0] ERR_LIMIT_RST  = 8'd7;

    typedef struct packed {
        logic              message_ok;
        logic [1:0]        request_kind;
        logic              error_present;
        logic [BYTE_W-1:0] error_code;
        logic              caps_present;
        logic [BYTE_W-1:0] caps_value;
    } tlvp_result_t;

endpackage

>>> hdl/tlvp_parser.sv
// Per-message parse state and the result decode for the final word.
`timescale 1ns / 1ps

module tlvp_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [tlvp_pkg::BYTE_W-1:0] data_byte,
    input  logic                        last_byte,
    input  logic [tlvp_pkg::BYTE_W-1:0] err_limit,
    output tlvp_pkg::tlvp_result_t      result
);
    import tlvp_pkg::*;

    typedef enum logic [1:0] {
        PH_ID,
        PH_SIZE,
        PH_VALUE,
        PH_DONE
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [1:0]        kind_reg, kind_next;
    logic              failed_reg, failed_next;
    logic              req_seen_reg, req_seen_next;
    logic [1:0]        req_value_reg, req_value_next;
    logic              err_seen_reg, err_seen_next;
    logic [BYTE_W-1:0] err_value_reg, err_value_next;
    logic              cap_seen_reg, cap_seen_next;
    logic [BYTE_W-1:0] cap_value_reg, cap_value_next;
    logic              ok;

    always_comb begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        failed_next    = failed_reg;
        req_seen_next  = req_seen_reg;
        req_value_next = req_value_reg;
        err_seen_next  = err_seen_reg;
        err_value_next = err_value_reg;
        cap_seen_next  = cap_seen_reg;
        cap_value_next = cap_value_reg;
        if (step) begin
            if (last_byte) begin
                // clear for the next message
                phase_next     = PH_ID;
                kind_next      = KIND_NONE;
                failed_next    = 1'b0;
                req_seen_next  = 1'b0;
                req_value_next = 2'd0;
                err_seen_next  = 1'b0;
                err_value_next = '0;
                cap_seen_next  = 1'b0;
                cap_value_next = '0;
            end else if (!failed_reg) begin
                case (phase_reg)
                    PH_ID: begin
                        if (data_byte == END_BYTE) begin
                            phase_next = PH_DONE;
                        end else if (data_byte <= {6'd0, KIND_CAPS}) begin
                            kind_next  = data_byte[1:0];
                            phase_next = PH_SIZE;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_SIZE: begin
                        if (data_byte != SIZE_REQUIRED) begin
                            failed_next = 1'b1;
                        end else begin
                            phase_next = PH_VALUE;
                        end
                    end
                    PH_VALUE: begin
                        phase_next = PH_ID;
                        case (kind_reg)
                            KIND_REQUEST: begin
                                if (data_byte > REQUEST_MAX) begin
                                    failed_next = 1'b1;
                                end else begin
                                    req_value_next = data_byte[1:0];
                                    req_seen_next  = 1'b1;
                                end
                            end
                            KIND_ERROR: begin
                                if (data_byte > err_limit) begin
                                    failed_next = 1'b1;
                                end else begin
                                    err_value_next = data_byte;
                                    err_seen_next  = 1'b1;
                                end
                            end
                            KIND_CAPS: begin
                                cap_value_next = data_byte;
                                cap_seen_next  = 1'b1;
                            end
                            default: failed_next = 1'b1;
                        endcase
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ID;
            kind_reg      <= KIND_NONE;
            failed_reg    <= 1'b0;
            req_seen_reg  <= 1'b0;
            req_value_reg <= 2'd0;
            err_seen_reg  <= 1'b0;
            err_value_reg <= '0;
            cap_seen_reg  <= 1'b0;
            cap_value_reg <= '0;
        end else begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            failed_reg    <= failed_next;
            req_seen_reg  <= req_seen_next;
            req_value_reg <= req_value_next;
            err_seen_reg  <= err_seen_next;
            err_value_reg <= err_value_next;
            cap_seen_reg  <= cap_seen_next;
            cap_value_reg <= cap_value_next;
        end
    end

    // A message is good only if it ended on an end byte at a header boundary
    assign ok = !failed_reg && req_seen_reg && (data_byte == END_BYTE) &&
                (phase_reg == PH_ID || phase_reg == PH_DONE);

    always_comb begin
        result = '0;
        if (ok) begin
            result.message_ok    = 1'b1;
            result.request_kind  = req_value_reg;
            result.error_present = err_seen_reg;
            result.error_code    = err_value_reg;
            result.caps_present  = cap_seen_reg;
            result.caps_value    = cap_value_reg;
        end
    end

endmodule

>>> hdl/tlv_signal_message_parser_top.sv
// Top level: input word register, parser, result register and limit register.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  input    | s_valid / s_ready   | s_data_byte, s_last_byte
//  result   | m_valid / m_ready   | m_message_ok .. m_caps_value
//  config   | cfg_valid/cfg_ready | cfg_data (error code limit)
//
// One word per cycle unless a final word waits; the parser works on the word in the
// input register, and a final word's result is registered and drives the m_ ports.
// Reset (synchronous, aresetn low) clears the parse state, empties both
// registers and loads the error code limit with 7.
// A final word waits in the input register while the result register is full
// and not taken; other words never wait on the result side.
`timescale 1ns / 1ps

module tlv_signal_message_parser_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tlvp_pkg::BYTE_W-1:0] s_data_byte,
    input  logic                        s_last_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_message_ok,
    output logic [1:0]                  m_request_kind,
    output logic                        m_error_present,
    output logic [tlvp_pkg::BYTE_W-1:0] m_error_code,
    output logic                        m_caps_present,
    output logic [tlvp_pkg::BYTE_W-1:0] m_caps_value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tlvp_pkg::BYTE_W-1:0] cfg_data
);
    import tlvp_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    tlvp_result_t      out_reg;
    tlvp_result_t      parsed;
    logic [BYTE_W-1:0] limit_reg;
    logic              out_free;
    logic              advance;

    assign out_free  = !out_valid_reg || m_ready;
    // hold a final word until the result register can take it
    assign advance   = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ERR_LIMIT_RST;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    tlvp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .err_limit (limit_reg),
        .result    (parsed)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= parsed;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_message_ok    = out_reg.message_ok;
    assign m_request_kind  = out_reg.request_kind;
    assign m_error_present = out_reg.error_present;
    assign m_error_code    = out_reg.error_code;
    assign m_caps_present  = out_reg.caps_present;
    assign m_caps_value    = out_reg.caps_value;

    // a good message never carries an out-of-range request
    a_req_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_message_ok) |-> (m_request_kind != 2'd3))
        else $error("request kind out of range on good message");

    // a failed message reports all fields as zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_message_ok) |->
            (m_request_kind == 2'd0 && !m_error_present && m_error_code == '0 &&
             !m_caps_present && m_caps_value == '0))
        else $error("failed message carries nonzero fields");

    // a stalled input word must be a final word blocked by a full result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_last_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // a new result follows an accepted final word
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid && !m_ready)) |->
            $past(advance && in_last_reg))
        else $error("result appeared without a final word");

endmodule

>>> tb/sv/tlv_signal_message_parser_top_tb.sv
// Testbench for the header/value message parser: random traffic, predicted results, checks.
`timescale 1ns / 1ps

module tlv_signal_message_parser_top_tb;

    import tlvp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 4;

    typedef enum logic [1:0] {
        AT_ID    = 2'd0,
        AT_SIZE  = 2'd1,
        AT_VALUE = 2'd2,
        AT_DONE  = 2'd3
    } parse_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_last;
    } msg_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte = '0;
    logic              s_last_byte = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_message_ok;
    logic [1:0]        m_request_kind;
    logic              m_error_present;
    logic [BYTE_W-1:0] m_error_code;
    logic              m_caps_present;
    logic [BYTE_W-1:0] m_caps_value;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data = '0;

    tlv_signal_message_parser_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_message_ok    (m_message_ok),
        .m_request_kind  (m_request_kind),
        .m_error_present (m_error_present),
        .m_error_code    (m_error_code),
        .m_caps_present  (m_caps_present),
        .m_caps_value    (m_caps_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    msg_word_t    word_q[$];
    tlvp_result_t result_q[$];

    // Parser shadow state
    logic [BYTE_W-1:0] err_limit = ERR_LIMIT_RST;
    parse_phase_t      prs_phase = AT_ID;
    logic [1:0]        prs_kind  = KIND_NONE;
    logic              prs_failed = 1'b0;
    logic              have_req  = 1'b0;
    logic [1:0]        req_val   = '0;
    logic              have_err  = 1'b0;
    logic [BYTE_W-1:0] err_val   = '0;
    logic              have_caps = 1'b0;
    logic [BYTE_W-1:0] caps_val  = '0;

    int   mismatches = 0;
    int   words_in = 0;
    int   send_gap = 0;
    int   ready_hold = 0;
    int   cycle_cnt = 0;
    int   gen_count = 0;
    logic long_hold_done = 1'b0;
    logic no_idle = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    task automatic clear_message();
        prs_phase  = AT_ID;
        prs_kind   = KIND_NONE;
        prs_failed = 1'b0;
        have_req   = 1'b0;
        req_val    = '0;
        have_err   = 1'b0;
        err_val    = '0;
        have_caps  = 1'b0;
        caps_val   = '0;
    endtask

    task automatic take_value(input logic [BYTE_W-1:0] b);
        case (prs_kind)
            KIND_REQUEST: begin
                if (b > REQUEST_MAX) begin
                    prs_failed = 1'b1;
                end else begin
                    req_val  = b[1:0];
                    have_req = 1'b1;
                end
            end
            KIND_ERROR: begin
                if (b > err_limit) begin
                    prs_failed = 1'b1;
                end else begin
                    err_val  = b;
                    have_err = 1'b1;
                end
            end
            KIND_CAPS: begin
                caps_val  = b;
                have_caps = 1'b1;
            end
            default: prs_failed = 1'b1;
        endcase
    endtask

    // Advance the shadow parser by one word; a final word queues its result
    task automatic parse_word(input logic [BYTE_W-1:0] b, input logic is_last);
        tlvp_result_t r;
        if (is_last) begin
            r = '0;
            if (!prs_failed && have_req && b == END_BYTE &&
                    (prs_phase == AT_ID || prs_phase == AT_DONE)) begin
                r.message_ok    = 1'b1;
                r.request_kind  = req_val;
                r.error_present = have_err;
                r.error_code    = err_val;
                r.caps_present  = have_caps;
                r.caps_value    = caps_val;
            end
            result_q.push_back(r);
            clear_message();
        end else if (!prs_failed) begin
            case (prs_phase)
                AT_ID: begin
                    if (b == END_BYTE) begin
                        prs_phase = AT_DONE;
                    end else if (b <= {6'd0, KIND_CAPS}) begin
                        prs_kind  = b[1:0];
                        prs_phase = AT_SIZE;
                    end else begin
                        prs_failed = 1'b1;
                    end
                end
                AT_SIZE: begin
                    if (b != SIZE_REQUIRED) prs_failed = 1'b1;
                    else prs_phase = AT_VALUE;
                end
                AT_VALUE: begin
                    take_value(b);
                    prs_phase = AT_ID;
                end
                default: ;
            endcase
        end
    endtask

    // Input driver
    always @(posedge aclk) begin
        msg_word_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                parse_word(s_data_byte, s_last_byte);
                words_in <= words_in + 1;
            end
            if (s_valid && !s_ready) begin
                // hold the word until taken
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (word_q.size() != 0) begin
                nxt = word_q.pop_front();
                s_data_byte <= nxt.data;
                s_last_byte <= nxt.is_last;
                s_valid     <= 1'b1;
                send_gap    <= pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side ready, with one long hold-off while the sender keeps offering
    always @(posedge aclk) begin
        int g;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (!long_hold_done && words_in >= 250 && word_q.size() > 60) begin
            long_hold_done <= 1'b1;
            ready_hold     <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else begin
            g = pick_gap();
            if (g == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= g - 1;
            end
        end
    end

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result monitor
    always @(posedge aclk) begin
        tlvp_result_t got;
        tlvp_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_message_ok, m_request_kind, m_error_present, m_error_code,
                   m_caps_present, m_caps_value};
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                mismatches++;
            end else begin
                want = result_q.pop_front();
                check_field("message_ok", 8'(want.message_ok), 8'(got.message_ok));
                check_field("request_kind", 8'(want.request_kind), 8'(got.request_kind));
                check_field("error_present", 8'(want.error_present),
                            8'(got.error_present));
                check_field("error_code", want.error_code, got.error_code);
                check_field("caps_present", 8'(want.caps_present), 8'(got.caps_present));
                check_field("caps_value", want.caps_value, got.caps_value);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic is_last);
        msg_word_t w;
        w.data    = b;
        w.is_last = is_last;
        word_q.push_back(w);
        gen_count++;
    endtask

    task automatic push_hdr(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] sz,
                            input logic [BYTE_W-1:0] v);
        push_word(id, 1'b0);
        push_word(sz, 1'b0);
        push_word(v, 1'b0);
    endtask

    // Mostly well-formed messages with random content; the rest noise or broken
    task automatic gen_message();
        int r;
        int n;
        int k;
        int req_slot;
        int c;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] sz;
        logic [BYTE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            n = $urandom_range(1, 8);
            for (k = 0; k < n - 1; k++) begin
                if ($urandom_range(0, 3) == 0) push_word(8'($urandom_range(0, 255)), 1'b0);
                else push_word(8'($urandom_range(0, 4)), 1'b0);
            end
            push_word($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(0, 255)), 1'b1);
            return;
        end
        n = $urandom_range(1, 4);
        req_slot = ($urandom_range(0, 9) != 0) ? $urandom_range(0, n - 1) : -1;
        for (k = 0; k < n; k++) begin
            if (k == req_slot) id = {6'd0, KIND_REQUEST};
            else if (req_slot < 0) id = 8'($urandom_range(2, 3));
            else id = 8'($urandom_range(1, 3));
            sz = SIZE_REQUIRED;
            case (id[1:0])
                KIND_REQUEST: begin
                    v = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 2))
                                                    : 8'($urandom_range(3, 255));
                end
                KIND_ERROR: begin
                    if ($urandom_range(0, 99) < 85 || err_limit == 8'hFF)
                        v = 8'($urandom_range(0, err_limit));
                    else
                        v = 8'($urandom_range(err_limit + 1, 255));
                end
                default: v = 8'($urandom_range(0, 255));
            endcase
            c = $urandom_range(0, 99);
            if (c < 3) id = 8'($urandom_range(4, 255));
            else if (c < 6) sz = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(2, 255));
            push_hdr(id, sz, v);
        end
        r = $urandom_range(0, 99);
        if (r < 80) begin
            push_word(END_BYTE, 1'b1);
        end else if (r < 88) begin
            // bytes after the end byte are dropped
            push_word(END_BYTE, 1'b0);
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) push_word(8'($urandom_range(0, 255)), 1'b0);
            push_word($urandom_range(0, 3) != 0 ? 8'd0 : 8'($urandom_range(1, 255)), 1'b1);
        end else if (r < 93) begin
            push_word(8'($urandom_range(1, 255)), 1'b1);
        end else if (r < 97) begin
            push_word(8'($urandom_range(1, 3)), 1'b0);
            push_word($urandom_range(0, 1) ? 8'd0 : SIZE_REQUIRED, 1'b1);
        end else begin
            push_word(8'($urandom_range(1, 3)), 1'b0);
            push_word(SIZE_REQUIRED, 1'b0);
            push_word(END_BYTE, 1'b1);
        end
    endtask

    task automatic gen_phase(input int n_words);
        @(negedge aclk);
        gen_count = 0;
        while (gen_count < n_words) gen_message();
    endtask

    // Wait until every word is taken and every result checked, then let the pipe empty
    task automatic settle();
        while (word_q.size() != 0 || s_valid || result_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_limit(input logic [BYTE_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        err_limit = v;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // all three headers, field extremes, error code at the reset limit
        push_hdr({6'd0, KIND_REQUEST}, SIZE_REQUIRED, REQUEST_MAX);
        push_hdr({6'd0, KIND_ERROR}, SIZE_REQUIRED, ERR_LIMIT_RST);
        push_hdr({6'd0, KIND_CAPS}, SIZE_REQUIRED, 8'hFF);
        push_word(END_BYTE, 1'b1);
        // unknown id
        push_word(8'hFF, 1'b0);
        push_word(END_BYTE, 1'b1);
        // wrong size
        push_word({6'd0, KIND_REQUEST}, 1'b0);
        push_word(8'd0, 1'b0);
        push_word(END_BYTE, 1'b1);
        // request out of range
        push_hdr({6'd0, KIND_REQUEST}, SIZE_REQUIRED, 8'd3);
        push_word(END_BYTE, 1'b1);
        // header cut in the value position, nonzero final byte
        push_word({6'd0, KIND_REQUEST}, 1'b0);
        push_word(SIZE_REQUIRED, 1'b0);
        push_word(8'h01, 1'b1);
        // end byte early, trailing bytes dropped
        push_hdr({6'd0, KIND_REQUEST}, SIZE_REQUIRED, 8'd1);
        push_word(END_BYTE, 1'b0);
        push_word(8'hAA, 1'b0);
        push_word(END_BYTE, 1'b1);
        // no request header
        push_hdr({6'd0, KIND_CAPS}, SIZE_REQUIRED, 8'h55);
        push_word(END_BYTE, 1'b1);
        settle();

        gen_phase(200);
        settle();
        set_limit(8'd0);
        gen_phase(200);
        settle();
        set_limit(8'hFF);
        no_idle = 1'b1;
        gen_phase(150);
        settle();
        no_idle = 1'b0;
        set_limit(8'($urandom_range(1, 254)));
        gen_phase(150);
        settle();
        set_limit(ERR_LIMIT_RST);
        gen_phase(100);
        settle();
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/tlvp_pkg.sv
hdl/tlvp_parser.sv
hdl/tlv_signal_message_parser_top.sv
tb/sv/tlv_signal_message_parser_top_tb.sv
